>>> sv/boxavg_pkg.sv
// Shared types and constants for the box-average downsampler.
// Used by the front, back, top level and testbench; depends on nothing.
`timescale 1ns / 1ps

package boxavg_pkg;

  // Parameter defaults
  localparam int DEF_MAX_WIDTH   = 4096;
  localparam int DEF_MAX_FACTOR  = 8;
  localparam int DEF_SAMPLE_BITS = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam int FACTOR_BITS = 4;
  localparam int FACTOR_MIN  = 2;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int ROW_W        = 12;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } res_flags_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage

>>> sv/boxavg_fifo.sv
// Short transaction queue between the accumulate front and the divide back.
// Does not use boxavg_pkg; generic in width/depth.
`timescale 1ns / 1ps

module boxavg_fifo #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [DATA_W-1:0]          push_data,
  input  logic                       pop,
  output logic [DATA_W-1:0]          pop_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH+1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0]  level_r, level_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = slot_r[rd_ptr_r];
  assign empty    = (level_r == '0);
  assign level    = level_r;

endmodule

>>> sv/boxavg_front.sv
// Front end: configuration registers, raster position counters and the
// column-sum line store. Emits finished block sums and pixel counts; uses boxavg_pkg.
`timescale 1ns / 1ps

module boxavg_front #(
  parameter int MAX_WIDTH   = 4096,
  parameter int MAX_FACTOR  = 8,
  parameter int SAMPLE_BITS = 16,
  parameter int SUM_W       = 22,
  parameter int CNT_W       = 7,
  parameter int LVL_W       = 3
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [boxavg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [boxavg_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [LVL_W-1:0]                     q_level,
  output logic                                 q_push,
  output logic signed [SUM_W-1:0]              q_sum,
  output logic [CNT_W-1:0]                     q_cnt,
  output boxavg_pkg::res_flags_t               q_flags
);

  import boxavg_pkg::*;

  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int STORE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int OC_W        = $clog2(STORE_DEPTH);
  localparam int CIB_W       = $clog2(MAX_FACTOR);
  localparam int PROD_W      = 2 * CIB_W + 2;
  localparam int W_RESET     = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;

  // Effective configuration, kept as "last index" values
  logic [CIB_W-1:0] f_last_r, f_last_nxt;
  logic [COL_W-1:0] w_last_r, w_last_nxt;
  logic [ROW_W-1:0] h_last_r, h_last_nxt;
  logic             cfg_hit;

  // Position counters
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CIB_W-1:0] cib_r, cib_nxt;
  logic [CIB_W-1:0] rib_r, rib_nxt;
  logic [OC_W-1:0]  oc_r, oc_nxt;

  logic accept;
  logic last_col, last_row, block_right, block_bottom;
  logic signed [SUM_W-1:0] s_ext, piece;
  logic signed [SUM_W-1:0] hacc_r;
  logic [CIB_W:0]  cw, rh;
  logic [PROD_W-1:0] prod;

  // Line store
  logic [SUM_W-1:0] mem [STORE_DEPTH];
  logic [SUM_W-1:0] rdata_r;

  // Store update stage
  logic                    sb_valid_r;
  logic [OC_W-1:0]         sb_idx_r;
  logic signed [SUM_W-1:0] sb_piece_r;
  logic                    sb_first_r;
  logic                    sb_bottom_r;
  logic [CNT_W-1:0]        sb_cnt_r;
  res_flags_t              sb_flags_r;
  logic                    fwd_r;
  logic signed [SUM_W-1:0] fwd_data_r;
  logic signed [SUM_W-1:0] sb_total;
  logic                    sb_push;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !in_full;

  // Config decode and clamping
  always_comb begin
    int fv;
    int wv;
    int hv;
    fv = int'(cfg_data[FACTOR_BITS-1:0]);
    wv = int'(cfg_data);
    hv = int'(cfg_data);
    if (fv < FACTOR_MIN) fv = FACTOR_MIN;
    if (fv > MAX_FACTOR) fv = MAX_FACTOR;
    if (wv < 1) wv = 1;
    if (wv > MAX_WIDTH) wv = MAX_WIDTH;
    if (hv < 1) hv = 1;
    if (hv > HEIGHT_LIMIT) hv = HEIGHT_LIMIT;
    f_last_nxt = f_last_r;
    w_last_nxt = w_last_r;
    h_last_nxt = h_last_r;
    cfg_hit    = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_SCALE_FACTOR: begin
          f_last_nxt = CIB_W'(fv - 1);
          cfg_hit    = 1'b1;
        end
        REG_FRAME_WIDTH: begin
          w_last_nxt = COL_W'(wv - 1);
          cfg_hit    = 1'b1;
        end
        REG_FRAME_HEIGHT: begin
          h_last_nxt = ROW_W'(hv - 1);
          cfg_hit    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Position bookkeeping
  always_comb begin
    last_col     = (col_r == w_last_r);
    last_row     = (row_r == h_last_r);
    block_right  = last_col || (cib_r == f_last_r);
    block_bottom = last_row || (rib_r == f_last_r);
    s_ext = SUM_W'(in_sample);
    piece = (cib_r == '0) ? s_ext : hacc_r + s_ext;
    cw    = {1'b0, cib_r} + 1'b1;
    rh    = {1'b0, rib_r} + 1'b1;
    prod  = PROD_W'(cw) * PROD_W'(rh);

    col_nxt = col_r;
    row_nxt = row_r;
    cib_nxt = cib_r;
    rib_nxt = rib_r;
    oc_nxt  = oc_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
      cib_nxt = '0;
      rib_nxt = '0;
      oc_nxt  = '0;
    end else if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        cib_nxt = '0;
        oc_nxt  = '0;
        rib_nxt = block_bottom ? '0 : rib_r + 1'b1;
        row_nxt = last_row ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
        if (cib_r == f_last_r) begin
          cib_nxt = '0;
          oc_nxt  = oc_r + 1'b1;
        end else begin
          cib_nxt = cib_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_last_r   <= CIB_W'(FACTOR_MIN - 1);
      w_last_r   <= COL_W'(W_RESET - 1);
      h_last_r   <= ROW_W'(HEIGHT_LIMIT - 1);
      col_r      <= '0;
      row_r      <= '0;
      cib_r      <= '0;
      rib_r      <= '0;
      oc_r       <= '0;
      sb_valid_r <= 1'b0;
    end else begin
      f_last_r   <= f_last_nxt;
      w_last_r   <= w_last_nxt;
      h_last_r   <= h_last_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      cib_r      <= cib_nxt;
      rib_r      <= rib_nxt;
      oc_r       <= oc_nxt;
      sb_valid_r <= accept && block_right;
    end
  end

  // Row piece of a block: horizontal sum handed to the store update stage
  always_ff @(posedge clk) begin
    if (accept) begin
      hacc_r      <= piece;
      sb_idx_r    <= oc_r;
      sb_piece_r  <= piece;
      sb_first_r  <= (rib_r == '0);
      sb_bottom_r <= block_bottom;
      sb_cnt_r    <= prod[CNT_W-1:0];
      sb_flags_r  <= '{row_end: last_col, frame_end: last_col && last_row};
      // store write of the previous piece lands on this same edge
      fwd_r       <= sb_valid_r && (sb_idx_r == oc_r);
      fwd_data_r  <= sb_total;
    end
  end

  always_comb begin
    if (sb_first_r) begin
      sb_total = sb_piece_r;
    end else if (fwd_r) begin
      sb_total = fwd_data_r + sb_piece_r;
    end else begin
      sb_total = $signed(rdata_r) + sb_piece_r;
    end
  end

  always_ff @(posedge clk) begin
    if (sb_valid_r) begin
      mem[sb_idx_r] <= sb_total;
    end
    if (accept) begin
      rdata_r <= mem[oc_r];
    end
  end

  assign sb_push = sb_valid_r && sb_bottom_r;
  assign q_push  = sb_push;
  assign q_sum   = sb_total;
  assign q_cnt   = sb_cnt_r;
  assign q_flags = sb_flags_r;

  // Reserve a queue slot for the piece still in the update stage
  assign in_full = ({1'b0, q_level} + (LVL_W+1)'(sb_push)) >= (LVL_W+1)'(QUEUE_DEPTH);

endmodule

>>> sv/boxavg_back.sv
// Back end: rounded mean of each block sum by a bit-serial restoring divider,
// and the result register. Uses boxavg_pkg for the state type and flag struct.
`timescale 1ns / 1ps

module boxavg_back #(
  parameter int SAMPLE_BITS = 16,
  parameter int SUM_W       = 22,
  parameter int CNT_W       = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  logic signed [SUM_W-1:0]       q_sum,
  input  logic [CNT_W-1:0]              q_cnt,
  input  boxavg_pkg::res_flags_t        q_flags,
  output logic                          q_pop,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic signed [SAMPLE_BITS-1:0] out_average,
  output logic                          out_row_end,
  output logic                          out_frame_end
);

  import boxavg_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  back_state_t       state_r, state_nxt;
  logic              neg_r, neg_nxt;
  logic [SUM_W-1:0]  dvd_r, dvd_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  div_r, div_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  res_flags_t        flags_r, flags_nxt;

  logic                          res_valid_r, res_valid_nxt;
  logic [SAMPLE_BITS-1:0]        res_avg_r, res_avg_nxt;
  res_flags_t                    res_flags_r, res_flags_nxt;

  logic [SUM_W-1:0] mag;
  logic [CNT_W:0]   rem_sh, rem_sub;
  logic             ge;
  logic [SUM_W-1:0] q_neg;
  logic             take;

  always_comb begin
    mag     = q_sum[SUM_W-1] ? (~q_sum + 1'b1) : q_sum;
    mag     = mag + SUM_W'(q_cnt >> 1);
    rem_sh  = {rem_r, dvd_r[SUM_W-1]};
    rem_sub = rem_sh - {1'b0, div_r};
    ge      = (rem_sh >= {1'b0, div_r});
    q_neg   = ~dvd_r + 1'b1;
    take    = out_pop && res_valid_r;

    state_nxt     = state_r;
    neg_nxt       = neg_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    step_nxt      = step_r;
    flags_nxt     = flags_r;
    res_avg_nxt   = res_avg_r;
    res_flags_nxt = res_flags_r;
    res_valid_nxt = res_valid_r && !take;
    q_pop         = 1'b0;

    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          neg_nxt   = q_sum[SUM_W-1];
          dvd_nxt   = mag;
          rem_nxt   = '0;
          div_nxt   = q_cnt;
          step_nxt  = STEP_W'(SUM_W);
          flags_nxt = q_flags;
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        rem_nxt  = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        dvd_nxt  = {dvd_r[SUM_W-2:0], ge};
        step_nxt = step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!res_valid_r || take) begin
          res_avg_nxt   = neg_r ? q_neg[SAMPLE_BITS-1:0] : dvd_r[SAMPLE_BITS-1:0];
          res_flags_nxt = flags_r;
          res_valid_nxt = 1'b1;
          state_nxt     = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r       <= neg_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    div_r       <= div_nxt;
    step_r      <= step_nxt;
    flags_r     <= flags_nxt;
    res_avg_r   <= res_avg_nxt;
    res_flags_r <= res_flags_nxt;
  end

  assign out_empty     = !res_valid_r;
  assign out_average   = res_avg_r;
  assign out_row_end   = res_flags_r.row_end;
  assign out_frame_end = res_flags_r.frame_end;

endmodule

>>> sv/box_average_downsample_unit.sv
// Box-average downsampler, top level: front, transaction queue, back.
// Input: one sample per cycle while in_full is low (queue of QUEUE_DEPTH sums).
// The back end pops a sum in BK_IDLE, divides it in BK_DIV, one quotient bit per
// cycle, and takes the next sum only after BK_DONE has written the result.
// Reset (rst_n low, synchronous) restores default config and clears counters and
// queue; the line store is not cleared, each entry is written before it is read.
`timescale 1ns / 1ps

module box_average_downsample_unit #(
  parameter int MAX_WIDTH   = boxavg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_FACTOR  = boxavg_pkg::DEF_MAX_FACTOR,
  parameter int SAMPLE_BITS = boxavg_pkg::DEF_SAMPLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [SAMPLE_BITS-1:0]     out_average,
  output logic                              out_row_end,
  output logic                              out_frame_end,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [boxavg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [boxavg_pkg::CFG_DATA_W-1:0] cfg_data
);

  import boxavg_pkg::*;

  localparam int SUM_W  = SAMPLE_BITS + 2 * $clog2(MAX_FACTOR);
  localparam int CNT_W  = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
  localparam int FLAG_W = $bits(res_flags_t);
  localparam int Q_W    = SUM_W + CNT_W + FLAG_W;
  localparam int LVL_W  = $clog2(QUEUE_DEPTH + 1);

  logic                    q_push, q_pop, q_empty;
  logic [LVL_W-1:0]        q_level;
  logic signed [SUM_W-1:0] f_sum, b_sum;
  logic [CNT_W-1:0]        f_cnt, b_cnt;
  res_flags_t              f_flags, b_flags;
  logic [Q_W-1:0]          q_wdata, q_rdata;

  boxavg_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR),
    .SAMPLE_BITS(SAMPLE_BITS),
    .SUM_W      (SUM_W),
    .CNT_W      (CNT_W),
    .LVL_W      (LVL_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_sample(in_sample),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_level  (q_level),
    .q_push   (q_push),
    .q_sum    (f_sum),
    .q_cnt    (f_cnt),
    .q_flags  (f_flags)
  );

  assign q_wdata = {f_sum, f_cnt, f_flags};

  boxavg_fifo #(
    .DATA_W(Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .empty    (q_empty),
    .level    (q_level)
  );

  assign b_sum   = q_rdata[Q_W-1 -: SUM_W];
  assign b_cnt   = q_rdata[FLAG_W +: CNT_W];
  assign b_flags = q_rdata[FLAG_W-1:0];

  boxavg_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .SUM_W      (SUM_W),
    .CNT_W      (CNT_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_sum        (b_sum),
    .q_cnt        (b_cnt),
    .q_flags      (b_flags),
    .q_pop        (q_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_average  (out_average),
    .out_row_end  (out_row_end),
    .out_frame_end(out_frame_end)
  );

endmodule

>>> sv/boxavg_checker.sv
// Port-level checks for box_average_downsample_unit, attached by bind.
// Depends on the top level's port list only.
`timescale 1ns / 1ps

module boxavg_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_full,
  input logic                   out_empty,
  input logic                   out_pop,
  input logic [SAMPLE_BITS-1:0] out_average,
  input logic                   out_row_end,
  input logic                   out_frame_end
);

  // reset drains the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending after reset");

  // queue starts with room after reset
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

  // the last result of a frame also closes its output row
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_frame_end |-> out_row_end)
    else $error("frame_end without row_end");

  // a waiting transaction holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_average)
      && $stable(out_row_end) && $stable(out_frame_end))
    else $error("pending result changed before pop");

endmodule

bind box_average_downsample_unit boxavg_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_boxavg_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_full      (in_full),
  .out_empty    (out_empty),
  .out_pop      (out_pop),
  .out_average  (out_average),
  .out_row_end  (out_row_end),
  .out_frame_end(out_frame_end)
);

>>> tb/sv/box_average_downsample_unit_tb.sv
// Testbench for box_average_downsample_unit: directed frames, then random frames.
// Predicts every block average in SV and checks it against the result queue port.
// Depends on boxavg_pkg and the box_average_downsample_unit RTL.
`timescale 1ns / 1ps

module box_average_downsample_unit_tb;
  import boxavg_pkg::*;

  localparam int SB           = DEF_SAMPLE_BITS;
  localparam int STORE_DEPTH  = DEF_MAX_WIDTH / 2;
  localparam int RANDOM_ITEMS = 1300;
  localparam int SETTLE       = 40;    // a bit over the divider latency
  localparam int STALL_LIMIT  = 4000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic signed [SB-1:0] average;
    logic                 row_end;
    logic                 frame_end;
  } block_avg_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic signed [SB-1:0] in_sample = '0;
  logic out_pop = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  wire in_full, out_empty, cfg_ready;
  wire signed [SB-1:0] out_average;
  wire out_row_end, out_frame_end;

  box_average_downsample_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_sample(in_sample),
    .out_empty(out_empty), .out_pop(out_pop), .out_average(out_average),
    .out_row_end(out_row_end), .out_frame_end(out_frame_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [SB-1:0] sample_queue [$];
  block_avg_t avg_expected [$];
  int unsigned err_count = 0;
  int unsigned send_idle_pct = 32;
  int unsigned recv_idle_pct = 80;
  bit in_stalled = 1'b0;
  int unsigned stall_cycles = 0;

  // Predictor state
  int col_sum [STORE_DEPTH];
  int unsigned reg_factor = 2, reg_width = 4096, reg_height = 4096;
  int unsigned pix_col = 0, pix_row = 0, col_in_blk = 0, row_in_band = 0, out_col = 0;

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic clear_position();
    pix_col = 0;
    pix_row = 0;
    col_in_blk = 0;
    row_in_band = 0;
    out_col = 0;
  endtask

  task automatic predict_block_avg(input logic signed [SB-1:0] s);
    int unsigned f, w, h, idx, cnt, mag, q;
    bit last_col, last_row, blk_bottom;
    int sum;
    block_avg_t r;
    f = clamp(reg_factor, FACTOR_MIN, DEF_MAX_FACTOR);
    w = clamp(reg_width, 1, DEF_MAX_WIDTH);
    h = clamp(reg_height, 1, HEIGHT_LIMIT);
    idx = out_col % STORE_DEPTH;
    if (row_in_band == 0 && col_in_blk == 0) col_sum[idx] = s;
    else col_sum[idx] += s;
    last_col = pix_col + 1 >= w;
    last_row = pix_row + 1 >= h;
    blk_bottom = last_row || row_in_band + 1 >= f;
    if ((last_col || col_in_blk + 1 >= f) && blk_bottom) begin
      cnt = (col_in_blk + 1) * (row_in_band + 1);
      sum = col_sum[idx];
      mag = (sum < 0) ? -sum : sum;
      q = (mag + cnt / 2) / cnt;
      r.average = SB'((sum < 0) ? -int'(q) : int'(q));
      r.row_end = last_col;
      r.frame_end = last_col && last_row;
      avg_expected.push_back(r);
    end
    if (last_col) begin
      pix_col = 0;
      col_in_blk = 0;
      out_col = 0;
      row_in_band = blk_bottom ? 0 : row_in_band + 1;
      pix_row = last_row ? 0 : pix_row + 1;
    end else begin
      pix_col++;
      if (col_in_blk + 1 >= f) begin
        col_in_blk = 0;
        out_col++;
      end else begin
        col_in_blk++;
      end
    end
  endtask

  // Driver: inputs change on the falling edge; a stalled push is held as is.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      out_pop <= 1'b0;
    end else begin
      if (sample_queue.size() != 0 &&
          (in_stalled || $urandom_range(99) >= send_idle_pct)) begin
        in_push <= 1'b1;
        in_sample <= sample_queue[0];
      end else begin
        in_push <= 1'b0;
      end
      out_pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: samples every transaction on the rising edge.
  always @(posedge clk) begin
    block_avg_t e;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      in_stalled = in_push && in_full;
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          REG_SCALE_FACTOR: begin
            reg_factor = cfg_data[FACTOR_BITS-1:0];
            clear_position();
          end
          REG_FRAME_WIDTH: begin
            reg_width = cfg_data;
            clear_position();
          end
          REG_FRAME_HEIGHT: begin
            reg_height = cfg_data;
            clear_position();
          end
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        moved = 1'b1;
        void'(sample_queue.pop_front());
        predict_block_avg(in_sample);
      end
      if (out_pop && !out_empty) begin
        moved = 1'b1;
        if (avg_expected.size() == 0) begin
          $error("unexpected result: average %0d row_end %0b frame_end %0b",
                 out_average, out_row_end, out_frame_end);
          err_count++;
        end else begin
          e = avg_expected.pop_front();
          if (out_average !== e.average) begin
            $error("average: expected %0d, got %0d", e.average, out_average);
            err_count++;
          end
          if (out_row_end !== e.row_end) begin
            $error("row_end: expected %0b, got %0b", e.row_end, out_row_end);
            err_count++;
          end
          if (out_frame_end !== e.frame_end) begin
            $error("frame_end: expected %0b, got %0b", e.frame_end, out_frame_end);
            err_count++;
          end
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (sample_queue.size() != 0 || avg_expected.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(data);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Drains the block, optionally pokes the unused index, then programs all three registers.
  task automatic configure(input int unsigned f_data, input int unsigned w,
                           input int unsigned h, input bit poke_unused);
    wait_drained();
    if (poke_unused) write_reg(REG_UNUSED, $urandom_range(8191));
    write_reg(REG_SCALE_FACTOR, f_data);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [SB-1:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(9);
    case (pick)
      0: return 16'sh7FFF;
      1: return -16'sh8000;
      2, 3: return SB'($urandom_range(8) - 4);
      default: return SB'($urandom);
    endcase
  endfunction

  task automatic set_idling(input int unsigned done_items);
    if (done_items < RANDOM_ITEMS / 3) begin
      send_idle_pct = 32;
      recv_idle_pct = 80;
    end else if (done_items < 2 * RANDOM_ITEMS / 3) begin
      send_idle_pct = 80;
      recv_idle_pct = 32;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  initial begin
    int unsigned done_items, kind, f, f_data, w, h, ew, eh, n;
    done_items = 0;
    set_idling(0);
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Ties away from zero on a two-pixel block
    configure(2, 4, 1, 1'b0);
    sample_queue.push_back(16'sd1);
    sample_queue.push_back(16'sd0);
    sample_queue.push_back(-16'sd1);
    sample_queue.push_back(16'sd0);

    // Extreme samples, partial right-hand block, two-row band
    configure(3, 4, 2, 1'b0);
    repeat (2) begin
      repeat (3) sample_queue.push_back(16'sh7FFF);
      sample_queue.push_back(-16'sh8000);
    end

    // Zero registers act as factor 2 and a one-pixel frame
    configure(0, 0, 0, 1'b1);
    sample_queue.push_back(-16'sh8000);
    sample_queue.push_back(16'sh7FFF);
    sample_queue.push_back(16'sh5555);
    sample_queue.push_back(-16'sh5556);

    // Oversized factor and width clamp to 8 and MAX_WIDTH; frame left unfinished
    configure(13'h1FFF, 8191, 1, 1'b0);
    repeat (8) sample_queue.push_back(-16'sh8000);
    sample_queue.push_back(16'sh7FFF);
    sample_queue.push_back(16'sh0001);

    // Oversized height clamps to 4096; one-column frame
    configure(2, 1, 8191, 1'b0);
    sample_queue.push_back(16'sd7);
    sample_queue.push_back(-16'sd8);
    sample_queue.push_back(-16'sd3);
    sample_queue.push_back(16'sd2);

    while (done_items < RANDOM_ITEMS) begin
      kind = $urandom_range(9);
      f = $urandom_range(DEF_MAX_FACTOR, FACTOR_MIN);
      f_data = f;
      w = $urandom_range(40, 1);
      h = $urandom_range(10, 1);
      case (kind)
        0: begin
          // out-of-range codes and junk in the unused factor bits
          f_data = $urandom_range(8191);
          w = $urandom_range(3);
          h = $urandom_range(3);
        end
        1: begin
          w = $urandom_range(300, 41);
          h = $urandom_range(2, 1);
        end
        2: begin
          w = $urandom_range(8191, DEF_MAX_WIDTH);
          h = $urandom_range(2, 1);
        end
        default: ;
      endcase
      ew = clamp(w, 1, DEF_MAX_WIDTH);
      eh = clamp(h, 1, HEIGHT_LIMIT);
      if (kind == 2) n = $urandom_range(200, 20);
      else if (kind == 9) n = $urandom_range(ew * eh, 1);
      else n = ew * eh * $urandom_range(2, 1);
      // last frame may be cut short to keep the total at RANDOM_ITEMS
      if (n > RANDOM_ITEMS - done_items) n = RANDOM_ITEMS - done_items;
      set_idling(done_items);
      configure(f_data, w, h, kind == 3);
      repeat (n) sample_queue.push_back(rand_sample());
      done_items += n;
    end

    while (sample_queue.size() != 0 || avg_expected.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (avg_expected.size() != 0) begin
      $error("%0d expected results never arrived", avg_expected.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
